// ===== design/spimsp_pkg.sv =====
`timescale 1ns / 1ps

package spimsp_pkg;

    // word size of the shift register and receive buffer
    localparam int unsigned DATA_WIDTH  = 8;
    localparam int unsigned BIT_COUNT_W = $clog2(DATA_WIDTH + 1);
    localparam int unsigned PRESCALE_W  = 7;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 2;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_MODE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LSB_LEADS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_POLARITY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_PHASE    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_SELECT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_SPEED   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_ENABLE     = 3'd7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic       miso_in;
        logic       mosi_in;
        logic       sck_in;
        logic       select_n;
    } req_t;

    typedef struct packed {
        logic       sck_out;
        logic       mosi_out;
        logic       miso_out;
        logic [7:0] read_data;
        logic       done_flag;
        logic       irq;
        logic       busy_res;
    } rsp_t;

    typedef struct packed {
        logic       port_enable;
        logic       master_mode;
        logic       lsb_leads;
        logic       clock_polarity;
        logic       clock_phase;
        logic [1:0] rate_select;
        logic       double_speed;
        logic       irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  shift_reg;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [PRESCALE_W-1:0]  prescale_count;
        logic                   clock_level;
        logic                   active;
        logic                   complete_flag;
        logic [DATA_WIDTH-1:0]  receive_buffer;
        logic                   last_sck_in;
        logic                   out_bit;
    } state_t;

    // ticks between two sck edges in master mode
    function automatic logic [PRESCALE_W-1:0] half_period(input logic [1:0] rate_select,
                                                          input logic       double_speed);
        logic [PRESCALE_W-1:0] half;
        begin
            unique case (rate_select)
                2'd0:    half = 7'd2;
                2'd1:    half = 7'd8;
                2'd2:    half = 7'd32;
                default: half = 7'd64;
            endcase
            if (double_speed)
            begin
                half = half >> 1;
            end
            return half;
        end
    endfunction

    // drop an exchange, keeping the partial word
    function automatic state_t abort_state(input state_t s);
        state_t r;
        begin
            r                = s;
            r.active         = 1'b0;
            r.bit_count      = '0;
            r.prescale_count = '0;
            r.clock_level    = 1'b0;
            return r;
        end
    endfunction

endpackage

// ===== design/spimsp_step.sv =====
`timescale 1ns / 1ps

// next state of the serial port for one request
module spimsp_step (
    input  spimsp_pkg::cfg_t   cfg,
    input  spimsp_pkg::state_t cur,
    input  spimsp_pkg::req_t   item,
    output spimsp_pkg::state_t nxt
);

    localparam int unsigned W = spimsp_pkg::DATA_WIDTH;

    logic                                    do_edge;
    logic                                    leading;
    logic                                    din;
    logic                                    end_bit;
    logic [W-1:0]                            shifted;
    logic [W-1:0]                            loaded;
    logic [spimsp_pkg::PRESCALE_W-1:0]       half;
    logic [spimsp_pkg::PRESCALE_W:0]         pre_inc;
    logic [spimsp_pkg::BIT_COUNT_W-1:0]      count_inc;
    logic [spimsp_pkg::BIT_COUNT_W-1:0]      count_after;

    // shift helpers on the current word
    assign half      = spimsp_pkg::half_period(cfg.rate_select, cfg.double_speed);
    assign pre_inc   = {1'b0, cur.prescale_count} + 1'b1;
    assign count_inc = cur.bit_count + 1'b1;
    assign din       = cfg.master_mode ? item.miso_in : item.mosi_in;
    assign end_bit   = cfg.lsb_leads ? cur.shift_reg[0] : cur.shift_reg[W-1];
    assign shifted   = cfg.lsb_leads ? {din, cur.shift_reg[W-1:1]}
                                     : {cur.shift_reg[W-2:0], din};
    assign loaded    = W'(item.write_data);

    always_comb
    begin
        nxt         = cur;
        do_edge     = 1'b0;
        leading     = 1'b0;
        count_after = cur.bit_count;

        // request decode
        unique case (item.req_type)
            spimsp_pkg::REQ_TICK:
            begin
                nxt.last_sck_in = item.sck_in;
                if (!cfg.port_enable)
                begin
                    nxt = spimsp_pkg::abort_state(nxt);
                end
                else if (cfg.master_mode)
                begin
                    if (cur.active)
                    begin
                        if (pre_inc >= {1'b0, half})
                        begin
                            nxt.prescale_count = '0;
                            do_edge            = 1'b1;
                            leading            = !cur.clock_level;
                        end
                        else
                        begin
                            nxt.prescale_count = pre_inc[spimsp_pkg::PRESCALE_W-1:0];
                        end
                    end
                end
                else if (item.select_n)
                begin
                    nxt = spimsp_pkg::abort_state(nxt);
                end
                else if (item.sck_in != cur.last_sck_in)
                begin
                    nxt.active = 1'b1;
                    do_edge    = 1'b1;
                    leading    = item.sck_in ^ cfg.clock_polarity;
                end
            end
            spimsp_pkg::REQ_WRITE:
            begin
                if (cfg.port_enable && !cur.active)
                begin
                    nxt.shift_reg      = loaded;
                    nxt.out_bit        = cfg.lsb_leads ? loaded[0] : loaded[W-1];
                    nxt.bit_count      = '0;
                    nxt.prescale_count = '0;
                    nxt.clock_level    = 1'b0;
                    if (cfg.master_mode)
                    begin
                        nxt.active = 1'b1;
                    end
                end
            end
            spimsp_pkg::REQ_READ:
            begin
                nxt.complete_flag = 1'b0;
            end
            default:
            begin
            end
        endcase

        // one sck edge: sample or set up, finish after the last bit
        if (do_edge)
        begin
            if (leading)
            begin
                nxt.clock_level = 1'b1;
                if (cfg.clock_phase)
                begin
                    nxt.out_bit = end_bit;
                end
                else
                begin
                    nxt.shift_reg = shifted;
                    nxt.bit_count = count_inc;
                end
            end
            else
            begin
                nxt.clock_level = 1'b0;
                if (cfg.clock_phase)
                begin
                    nxt.shift_reg = shifted;
                    nxt.bit_count = count_inc;
                    count_after   = count_inc;
                end
                else
                begin
                    nxt.out_bit = end_bit;
                end
                if (count_after >= spimsp_pkg::BIT_COUNT_W'(W))
                begin
                    nxt.receive_buffer = nxt.shift_reg;
                    nxt.complete_flag  = 1'b1;
                    nxt                = spimsp_pkg::abort_state(nxt);
                end
            end
        end
    end

endmodule

// ===== design/spi_master_slave_port.sv =====
`timescale 1ns / 1ps

// Byte-wide SPI port behind a register interface.
// req channel: one request per item (system tick, data register write or
// data register read) plus the sampled pin levels miso_in, mosi_in, sck_in
// and select_n. rsp channel: one response per request, showing the pin
// outputs, receive buffer, done flag, irq and busy after that request.
// cfg channel: register index and data, always ready, one register written
// per handshake; the user must write only while the port is idle, not
// enforced by the block. Indexes follow the register list. The response is
// valid the cycle after its request is taken. One request per cycle unless
// stalled, set by the single pass of next-state logic between the state and
// response registers. A stalled response holds its register and keeps
// req_ready low until it is taken; req_ready is high while the response
// register is empty or being taken. Reset clears all state, configuration
// and the response register; after reset the port is disabled in slave mode.
module spi_master_slave_port (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     req_valid,
    output logic                                     req_ready,
    input  spimsp_pkg::req_t                         req,
    output logic                                     rsp_valid,
    input  logic                                     rsp_ready,
    output spimsp_pkg::rsp_t                         rsp,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [spimsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [spimsp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    spimsp_pkg::cfg_t   cfg_reg;
    spimsp_pkg::state_t state_reg;
    spimsp_pkg::state_t state_next;
    spimsp_pkg::rsp_t   rsp_reg;
    spimsp_pkg::rsp_t   rsp_next;
    logic               rsp_valid_reg;
    logic               req_take;
    logic               enabled_master;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_take  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                spimsp_pkg::CFG_PORT_ENABLE:    cfg_reg.port_enable    <= cfg_data[0];
                spimsp_pkg::CFG_MASTER_MODE:    cfg_reg.master_mode    <= cfg_data[0];
                spimsp_pkg::CFG_LSB_LEADS:      cfg_reg.lsb_leads      <= cfg_data[0];
                spimsp_pkg::CFG_CLOCK_POLARITY: cfg_reg.clock_polarity <= cfg_data[0];
                spimsp_pkg::CFG_CLOCK_PHASE:    cfg_reg.clock_phase    <= cfg_data[0];
                spimsp_pkg::CFG_RATE_SELECT:    cfg_reg.rate_select    <= cfg_data[1:0];
                spimsp_pkg::CFG_DOUBLE_SPEED:   cfg_reg.double_speed   <= cfg_data[0];
                spimsp_pkg::CFG_IRQ_ENABLE:     cfg_reg.irq_enable     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // next-state logic for one request
    spimsp_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (req),
        .nxt  (state_next)
    );

    // response fields from the updated state
    assign enabled_master = cfg_reg.port_enable && cfg_reg.master_mode;

    always_comb
    begin
        rsp_next.sck_out   = enabled_master &&
                             (cfg_reg.clock_polarity ^
                              (state_next.active && state_next.clock_level));
        rsp_next.mosi_out  = enabled_master && state_next.out_bit;
        rsp_next.miso_out  = cfg_reg.port_enable && !cfg_reg.master_mode &&
                             !req.select_n && state_next.out_bit;
        rsp_next.read_data = 8'(state_next.receive_buffer);
        rsp_next.done_flag = state_next.complete_flag;
        rsp_next.irq       = state_next.complete_flag && cfg_reg.irq_enable;
        rsp_next.busy_res  = state_next.active;
    end

    // port state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (req_take)
        begin
            state_reg <= state_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_reg <= '0;
        end
        else if (req_take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // checks
    a_req_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> rsp_valid)
        else $error("request taken without a response");

    a_idle_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active |-> (state_reg.prescale_count == '0))
        else $error("prescaler running while idle");

    a_irq_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.irq) |-> rsp.done_flag)
        else $error("irq without done flag");

    a_busy_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (rsp.busy_res == state_reg.active))
        else $error("busy response out of step with state");

endmodule

// ===== tb/spi_master_slave_port_tb.sv =====
`timescale 1ns / 1ps

module spi_master_slave_port_tb;

    // spare request code, decoded as no operation
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int unsigned ITEM_TARGET = 900;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned REQ_BITS = $bits(spimsp_pkg::req_t);
    localparam int unsigned CFG_BITS = $bits(spimsp_pkg::cfg_t);

    // cycle-accurate mirror of the port, one response per request
    class port_mirror;
        spimsp_pkg::cfg_t                  cfg;
        logic [spimsp_pkg::DATA_WIDTH-1:0] shift_word;
        logic [spimsp_pkg::DATA_WIDTH-1:0] rx_buf;
        int unsigned                       bits_done;
        int unsigned                       prescale;
        bit                                clk_lvl;
        bit                                busy;
        bit                                done;
        bit                                last_sck;
        bit                                tx_bit;
        spimsp_pkg::rsp_t                  pending_rsp[$];
        int unsigned                       errors;
        int unsigned                       checked;
        int unsigned                       words_received;

        function new();
            cfg            = '0;
            shift_word     = '0;
            rx_buf         = '0;
            bits_done      = 0;
            prescale       = 0;
            clk_lvl        = 1'b0;
            busy           = 1'b0;
            done           = 1'b0;
            last_sck       = 1'b0;
            tx_bit         = 1'b0;
            errors         = 0;
            checked        = 0;
            words_received = 0;
        endfunction

        function void configure(logic [spimsp_pkg::CFG_INDEX_W-1:0] idx,
                                logic [spimsp_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                spimsp_pkg::CFG_PORT_ENABLE:    cfg.port_enable    = val[0];
                spimsp_pkg::CFG_MASTER_MODE:    cfg.master_mode    = val[0];
                spimsp_pkg::CFG_LSB_LEADS:      cfg.lsb_leads      = val[0];
                spimsp_pkg::CFG_CLOCK_POLARITY: cfg.clock_polarity = val[0];
                spimsp_pkg::CFG_CLOCK_PHASE:    cfg.clock_phase    = val[0];
                spimsp_pkg::CFG_RATE_SELECT:    cfg.rate_select    = val;
                spimsp_pkg::CFG_DOUBLE_SPEED:   cfg.double_speed   = val[0];
                spimsp_pkg::CFG_IRQ_ENABLE:     cfg.irq_enable     = val[0];
                default:            ;
            endcase
        endfunction

        // bit leaving the shift register next
        function bit outgoing_bit();
            return cfg.lsb_leads ? shift_word[0] : shift_word[spimsp_pkg::DATA_WIDTH-1];
        endfunction

        function void shift_bit(bit din);
            if (cfg.lsb_leads)
            begin
                shift_word = {din, shift_word[spimsp_pkg::DATA_WIDTH-1:1]};
            end
            else
            begin
                shift_word = {shift_word[spimsp_pkg::DATA_WIDTH-2:0], din};
            end
        endfunction

        function void drop_exchange();
            busy      = 1'b0;
            bits_done = 0;
            prescale  = 0;
            clk_lvl   = 1'b0;
        endfunction

        // ticks between two sck edges: half the sck period, which double speed halves
        function int unsigned half_ticks();
            int unsigned period;
            case (cfg.rate_select)
                2'd0:    period = 4;
                2'd1:    period = 16;
                2'd2:    period = 64;
                default: period = 128;
            endcase
            if (cfg.double_speed)
            begin
                period = period >> 1;
            end
            return period >> 1;
        endfunction

        function void sck_edge(bit leading, bit din);
            if (leading)
            begin
                clk_lvl = 1'b1;
                if (cfg.clock_phase)
                begin
                    tx_bit = outgoing_bit();
                end
                else
                begin
                    shift_bit(din);
                    bits_done++;
                end
            end
            else
            begin
                clk_lvl = 1'b0;
                if (cfg.clock_phase)
                begin
                    shift_bit(din);
                    bits_done++;
                end
                else
                begin
                    tx_bit = outgoing_bit();
                end
                // word complete on the trailing edge
                if (bits_done >= spimsp_pkg::DATA_WIDTH)
                begin
                    rx_buf = shift_word;
                    done   = 1'b1;
                    words_received++;
                    drop_exchange();
                end
            end
        endfunction

        function void system_tick(spimsp_pkg::req_t r);
            bit prev;
            prev     = last_sck;
            last_sck = r.sck_in;
            if (!cfg.port_enable)
            begin
                drop_exchange();
                return;
            end
            // master: prescaled sck while an exchange runs
            if (cfg.master_mode)
            begin
                if (!busy)
                begin
                    return;
                end
                if (prescale + 1 >= half_ticks())
                begin
                    prescale = 0;
                    sck_edge(!clk_lvl, r.miso_in);
                end
                else
                begin
                    prescale++;
                end
                return;
            end
            // slave: follow sck edges while selected
            if (r.select_n)
            begin
                drop_exchange();
                return;
            end
            if (r.sck_in != prev)
            begin
                busy = 1'b1;
                sck_edge(r.sck_in ^ cfg.clock_polarity, r.mosi_in);
            end
        endfunction

        function void take_request(spimsp_pkg::req_t r);
            spimsp_pkg::rsp_t e;
            bit               as_master;
            case (r.req_type)
                spimsp_pkg::REQ_TICK:  system_tick(r);
                spimsp_pkg::REQ_WRITE:
                begin
                    if (cfg.port_enable && !busy)
                    begin
                        shift_word = spimsp_pkg::DATA_WIDTH'(r.write_data);
                        tx_bit     = outgoing_bit();
                        bits_done  = 0;
                        prescale   = 0;
                        clk_lvl    = 1'b0;
                        if (cfg.master_mode)
                        begin
                            busy = 1'b1;
                        end
                    end
                end
                spimsp_pkg::REQ_READ:  done = 1'b0;
                default:   ;
            endcase
            as_master   = cfg.port_enable && cfg.master_mode;
            e.sck_out   = as_master ? (cfg.clock_polarity ^ (busy & clk_lvl)) : 1'b0;
            e.mosi_out  = as_master ? tx_bit : 1'b0;
            e.miso_out  = (cfg.port_enable && !cfg.master_mode && !r.select_n) ? tx_bit : 1'b0;
            e.read_data = 8'(rx_buf);
            e.done_flag = done;
            e.irq       = done & cfg.irq_enable;
            e.busy_res  = busy;
            pending_rsp.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("response %0d: %s expected %0h, got %0h", checked, name, want, seen);
                end
            end
        endfunction

        function void check_response(spimsp_pkg::rsp_t got);
            spimsp_pkg::rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                begin
                    $display("response with no request outstanding: %p", got);
                end
                return;
            end
            e = pending_rsp.pop_front();
            compare_field("sck_out", e.sck_out, got.sck_out);
            compare_field("mosi_out", e.mosi_out, got.mosi_out);
            compare_field("miso_out", e.miso_out, got.miso_out);
            compare_field("read_data", e.read_data, got.read_data);
            compare_field("done_flag", e.done_flag, got.done_flag);
            compare_field("irq", e.irq, got.irq);
            compare_field("busy_res", e.busy_res, got.busy_res);
            checked++;
        endfunction

        function int unsigned failures();
            return errors + pending_rsp.size();
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_ready;
    spimsp_pkg::req_t                   req = '0;
    logic                               rsp_valid;
    logic                               rsp_ready = 1'b0;
    spimsp_pkg::rsp_t                   rsp;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [spimsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [spimsp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    port_mirror  mirror;
    bit          quiet = 1'b0;
    int unsigned rsp_hold = 0;
    int unsigned items_sent = 0;
    int unsigned phases = 0;
    int unsigned cycles = 0;

    spi_master_slave_port i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("spi_master_slave_port_tb: done, errors");
            $finish;
        end
    end

    function int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 3);
    endfunction

    function spimsp_pkg::req_t random_request();
        spimsp_pkg::req_t r;
        r = spimsp_pkg::req_t'(REQ_BITS'($urandom));
        r.req_type = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // response side: check, then stall for a drawn number of cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                mirror.check_response(rsp);
                rsp_hold = draw_wait();
            end
            else if (rsp_hold > 0)
            begin
                rsp_hold--;
            end
            rsp_ready <= (rsp_hold == 0);
        end
    end

    // one request; valid stays high afterwards unless the next one waits
    task automatic send(spimsp_pkg::req_t r);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        mirror.take_request(r);
        items_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (mirror.pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [spimsp_pkg::CFG_INDEX_W-1:0] idx,
                             logic [spimsp_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        mirror.configure(idx, val);
    endtask

    // single-bit registers get a random spare bit above them
    function logic [spimsp_pkg::CFG_DATA_W-1:0] flag_word(bit b);
        logic [spimsp_pkg::CFG_DATA_W-1:0] v;
        v    = spimsp_pkg::CFG_DATA_W'($urandom);
        v[0] = b;
        return v;
    endfunction

    task automatic apply_config(spimsp_pkg::cfg_t c);
        drain();
        write_reg(spimsp_pkg::CFG_PORT_ENABLE, flag_word(c.port_enable));
        write_reg(spimsp_pkg::CFG_MASTER_MODE, flag_word(c.master_mode));
        write_reg(spimsp_pkg::CFG_LSB_LEADS, flag_word(c.lsb_leads));
        write_reg(spimsp_pkg::CFG_CLOCK_POLARITY, flag_word(c.clock_polarity));
        write_reg(spimsp_pkg::CFG_CLOCK_PHASE, flag_word(c.clock_phase));
        write_reg(spimsp_pkg::CFG_RATE_SELECT, c.rate_select);
        write_reg(spimsp_pkg::CFG_DOUBLE_SPEED, flag_word(c.double_speed));
        write_reg(spimsp_pkg::CFG_IRQ_ENABLE, flag_word(c.irq_enable));
        cfg_valid <= 1'b0;
        phases++;
    endtask

    // master exchange; a cut one is stopped by disabling the port mid-word
    task automatic master_exchange(bit cut_short);
        spimsp_pkg::req_t r;
        int unsigned      n;
        int unsigned      cut;
        r = random_request();
        r.req_type = spimsp_pkg::REQ_WRITE;
        send(r);
        cut = $urandom_range(1, 40);
        n   = 0;
        while (mirror.busy && n < 1500 && !(cut_short && n == cut))
        begin
            r = random_request();
            if ($urandom_range(0, 9) != 0)
            begin
                r.req_type = spimsp_pkg::REQ_TICK;
            end
            send(r);
            n++;
        end
        if (cut_short && mirror.busy)
        begin
            drain();
            write_reg(spimsp_pkg::CFG_PORT_ENABLE, flag_word(1'b0));
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
            begin
                r = random_request();
                r.req_type = spimsp_pkg::REQ_TICK;
                send(r);
            end
            drain();
            write_reg(spimsp_pkg::CFG_PORT_ENABLE, flag_word(1'b1));
            cfg_valid <= 1'b0;
        end
        r = random_request();
        r.req_type = spimsp_pkg::REQ_READ;
        send(r);
    endtask

    // slave exchange driven on sck_in; a cut one releases select mid-word
    task automatic slave_exchange(bit cut_short);
        spimsp_pkg::req_t r;
        bit               lvl;
        int unsigned      k;
        int unsigned      cut;
        lvl = mirror.cfg.clock_polarity;
        r = random_request();
        r.req_type = spimsp_pkg::REQ_TICK;
        r.sck_in   = lvl;
        r.select_n = 1'b1;
        send(r);
        if ($urandom_range(0, 3) != 0)
        begin
            r = random_request();
            r.req_type = spimsp_pkg::REQ_WRITE;
            r.select_n = 1'b0;
            send(r);
        end
        cut = cut_short ? $urandom_range(0, 15) : 2 * spimsp_pkg::DATA_WIDTH;
        for (k = 0; k < 2 * spimsp_pkg::DATA_WIDTH; k++)
        begin
            r = random_request();
            r.req_type = spimsp_pkg::REQ_TICK;
            r.sck_in   = lvl;
            if (k == cut)
            begin
                r.select_n = 1'b1;
                send(r);
                break;
            end
            r.select_n = 1'b0;
            repeat ($urandom_range(0, 2))
            begin
                r.mosi_in = 1'($urandom);
                send(r);
            end
            lvl        = ~lvl;
            r.sck_in   = lvl;
            r.mosi_in  = 1'($urandom);
            send(r);
        end
        r = random_request();
        r.req_type = spimsp_pkg::REQ_READ;
        send(r);
    endtask

    function spimsp_pkg::cfg_t random_config();
        spimsp_pkg::cfg_t c;
        int unsigned      roll;
        c = spimsp_pkg::cfg_t'(CFG_BITS'($urandom));
        c.port_enable = ($urandom_range(0, 7) != 0);
        roll = $urandom_range(0, 15);
        // mostly fast dividers, the slow ones now and then at double speed
        if (roll < 10)
        begin
            c.rate_select = 2'd0;
        end
        else if (roll < 14)
        begin
            c.rate_select = 2'd1;
        end
        else
        begin
            c.rate_select  = 2'(roll - 12);
            c.double_speed = 1'b1;
        end
        return c;
    endfunction

    initial
    begin
        spimsp_pkg::cfg_t c;
        int unsigned      k;
        int unsigned      roll;
        mirror = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // port disabled after reset: everything but reads has no effect
        send('{spimsp_pkg::REQ_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1});
        send('{spimsp_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1});
        send('{spimsp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0});
        send('{REQ_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1});
        send('{spimsp_pkg::REQ_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0});

        // fastest master exchange, with a write ignored halfway
        apply_config('{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 2'd0, 1'b1, 1'b1});
        send('{spimsp_pkg::REQ_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0});
        for (k = 0; k < 2 * spimsp_pkg::DATA_WIDTH; k++)
        begin
            if (k == spimsp_pkg::DATA_WIDTH)
            begin
                send('{spimsp_pkg::REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1});
            end
            send('{spimsp_pkg::REQ_TICK, 8'h00, 1'(k >> 1), 1'b0, 1'b0, 1'b0});
        end
        send('{spimsp_pkg::REQ_READ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0});

        // slowest divider at double speed, one full exchange
        apply_config('{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd3, 1'b1, 1'b0});
        master_exchange(1'b0);

        // random phases of well-formed, cut and noise traffic
        while (items_sent < ITEM_TARGET)
        begin
            c = random_config();
            apply_config(c);
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 4))
            begin
                if (items_sent < ITEM_TARGET)
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7 && c.master_mode)
                    begin
                        master_exchange(roll == 6);
                    end
                    else if (roll < 7)
                    begin
                        slave_exchange(roll == 6);
                    end
                    else
                    begin
                        repeat ($urandom_range(5, 15)) send(random_request());
                    end
                end
            end
        end
        quiet = 1'b0;

        drain();
        repeat (5) @(posedge clk);
        $display("%0d responses checked over %0d settings, %0d words received",
                 mirror.checked, phases, mirror.words_received);
        $display("master and slave exchanges, aborts, reads, ignored writes; %0d mismatches",
                 mirror.failures());
        if (mirror.failures() == 0)
        begin
            $display("spi_master_slave_port_tb: done, clean");
        end
        else
        begin
            $display("spi_master_slave_port_tb: done, errors");
        end
        $finish;
    end

endmodule
